// ===== src/spcp_pkg.sv =====
// ----------------------------------------------------------------------------
// spcp_pkg
// Shared types and constants for the segment pair closest point block.
// ----------------------------------------------------------------------------
package spcp_pkg;

    localparam logic [31:0] LIMIT_RESET = 32'd42950;
    localparam int          NUM_AXES    = 3;
    localparam int          NUM_COORDS  = 12;
    localparam int          NUM_OUTS    = 6;
    localparam int          CHUNK_BITS  = 32;

    typedef struct packed {
        logic full;
        logic nonempty;
    } t_q_stat;

    typedef struct packed {
        logic en;
        logic vld;
    } t_lane_ctl;

endpackage

// ===== src/spcp_front.sv =====
// ----------------------------------------------------------------------------
// spcp_front
// Ten stage front pipe: differences, dot products, determinant, parallel
// test, parameter clamping and snap. Emits one packed work item per beat.
// ----------------------------------------------------------------------------
module spcp_front
    import spcp_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_en,
    input  logic                           i_valid,
    input  logic [NUM_COORDS*COORD_BITS-1:0] i_data,
    input  logic [31:0]                    i_limit,
    output logic                           o_valid,
    output logic [6*COORD_BITS+6*(COORD_BITS+1)+4*(((2*(2*(COORD_BITS+1)+2)+1) >
                  ((2*(COORD_BITS+1)+2)+2*FRAC_BITS+2) ? (2*(2*(COORD_BITS+1)+2)+1) :
                  ((2*(COORD_BITS+1)+2)+2*FRAC_BITS+2)) > (4*FRAC_BITS+2) ?
                  ((2*(2*(COORD_BITS+1)+2)+1) > ((2*(COORD_BITS+1)+2)+2*FRAC_BITS+2) ?
                  (2*(2*(COORD_BITS+1)+2)+1) : ((2*(COORD_BITS+1)+2)+2*FRAC_BITS+2)) :
                  (4*FRAC_BITS+2))+1-1:0] o_item
);

    localparam int CB = COORD_BITS;
    localparam int F  = FRAC_BITS;
    localparam int DB = CB + 1;
    localparam int PW = 2 * DB;
    localparam int SW = PW + 2;
    localparam int TW = SW + 1;
    localparam int NA = 2 * SW + 1;
    localparam int NB = SW + 2 * F + 2;
    localparam int NC = 4 * F + 2;
    localparam int NT = (NA > NB) ? NA : NB;
    localparam int NW = (NT > NC) ? NT : NC;
    localparam int BW = NW + 31;
    localparam int OP = 0;
    localparam int OQ = 3 * CB;
    localparam int OU = 6 * CB;
    localparam int OV = 6 * CB + 3 * DB;
    localparam int GW = 6 * CB + 6 * DB;
    localparam logic signed [NW-1:0] ONE = NW'(1) <<< (4 * F);

    function automatic logic f_below(input logic signed [NW-1:0] x, input logic [31:0] lim);
        logic [BW-1:0] lhs;
        logic [BW-1:0] rhs;
        lhs = {x[NW-2:0], 32'b0};
        rhs = BW'(lim) << (4 * F);
        return x[NW-1] | (lhs < rhs);
    endfunction

    logic [9:0]               r_vld;
    logic [GW-1:0]            r_geo [1:10];
    logic [5*SW-1:0]          r_dot [3:8];

    logic signed [CB-1:0]     c_pt [NUM_COORDS];
    logic signed [DB-1:0]     c_u [NUM_AXES];
    logic signed [DB-1:0]     c_v [NUM_AXES];
    logic signed [DB-1:0]     c_w [NUM_AXES];
    logic [GW-1:0]            c_geo;

    logic signed [DB-1:0]     r1_u [NUM_AXES];
    logic signed [DB-1:0]     r1_v [NUM_AXES];
    logic signed [DB-1:0]     r1_w [NUM_AXES];
    logic signed [PW-1:0]     r2_uu [NUM_AXES];
    logic signed [PW-1:0]     r2_uv [NUM_AXES];
    logic signed [PW-1:0]     r2_vv [NUM_AXES];
    logic signed [PW-1:0]     r2_uw [NUM_AXES];
    logic signed [PW-1:0]     r2_vw [NUM_AXES];
    logic signed [SW-1:0]     c3_a, c3_b, c3_c, c3_d, c3_e;
    logic signed [SW-1:0]     d3_a, d3_b, d3_c, d3_d, d3_e;
    logic signed [2*SW-1:0]   r4_ac, r4_bb, r4_be, r4_cd, r4_ae, r4_bd;
    logic signed [NW-1:0]     r5_den, r5_sn, r5_tn;
    logic signed [NW-1:0]     r6_den, r6_sn, r6_tn;
    logic                     r6_par, r6_sneg, r6_sgt;
    logic signed [SW-1:0]     d6_b, d6_c, d6_e;
    logic signed [NW-1:0]     c7_sce, c7_sceb, c7_scc, c7_sn, c7_sd, c7_tn, c7_td;
    logic signed [NW-1:0]     r7_sn, r7_sd, r7_tn, r7_td;
    logic                     r7_par;
    logic signed [SW-1:0]     d7_a, d7_b, d7_d;
    logic signed [TW-1:0]     c8_t;
    logic signed [TW-1:0]     r8_t;
    logic signed [NW-1:0]     r8_sn, r8_sd, r8_tn, r8_td;
    logic                     r8_par, r8_tneg, r8_tgt, r8_tlo, r8_tha;
    logic signed [SW-1:0]     d8_a;
    logic signed [NW-1:0]     c9_sn, c9_sd, c9_tn;
    logic signed [NW-1:0]     r9_sn, r9_sd, r9_tn, r9_td;
    logic                     r9_par;
    logic signed [NW-1:0]     r10_sn, r10_sd, r10_tn, r10_td;
    logic                     r10_par;

    always_comb begin
        for (int k = 0; k < NUM_COORDS; k++) begin
            c_pt[k] = $signed(i_data[k*CB +: CB]);
        end
        c_geo = '0;
        for (int j = 0; j < NUM_AXES; j++) begin
            c_u[j] = DB'(c_pt[3+j]) - DB'(c_pt[j]);
            c_v[j] = DB'(c_pt[9+j]) - DB'(c_pt[6+j]);
            c_w[j] = DB'(c_pt[j]) - DB'(c_pt[6+j]);
            c_geo[OP + j*CB +: CB] = c_pt[j];
            c_geo[OQ + j*CB +: CB] = c_pt[6+j];
            c_geo[OU + j*DB +: DB] = c_u[j];
            c_geo[OV + j*DB +: DB] = c_v[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[8:0], i_valid};
        end
    end

    always_comb begin
        c3_a = SW'(r2_uu[0]) + SW'(r2_uu[1]) + SW'(r2_uu[2]);
        c3_b = SW'(r2_uv[0]) + SW'(r2_uv[1]) + SW'(r2_uv[2]);
        c3_c = SW'(r2_vv[0]) + SW'(r2_vv[1]) + SW'(r2_vv[2]);
        c3_d = SW'(r2_uw[0]) + SW'(r2_uw[1]) + SW'(r2_uw[2]);
        c3_e = SW'(r2_vw[0]) + SW'(r2_vw[1]) + SW'(r2_vw[2]);
        d3_a = $signed(r_dot[3][0*SW +: SW]);
        d3_b = $signed(r_dot[3][1*SW +: SW]);
        d3_c = $signed(r_dot[3][2*SW +: SW]);
        d3_d = $signed(r_dot[3][3*SW +: SW]);
        d3_e = $signed(r_dot[3][4*SW +: SW]);
        d6_b = $signed(r_dot[6][1*SW +: SW]);
        d6_c = $signed(r_dot[6][2*SW +: SW]);
        d6_e = $signed(r_dot[6][4*SW +: SW]);
        d7_a = $signed(r_dot[7][0*SW +: SW]);
        d7_b = $signed(r_dot[7][1*SW +: SW]);
        d7_d = $signed(r_dot[7][3*SW +: SW]);
        d8_a = $signed(r_dot[8][0*SW +: SW]);
    end

    always_comb begin
        c7_sce  = NW'(d6_e) <<< (2 * F);
        c7_sceb = (NW'(d6_e) + NW'(d6_b)) <<< (2 * F);
        c7_scc  = NW'(d6_c) <<< (2 * F);
        if (r6_par) begin
            c7_sn = '0;
            c7_sd = ONE;
            c7_tn = c7_sce;
            c7_td = c7_scc;
        end else if (r6_sneg) begin
            c7_sn = '0;
            c7_sd = r6_den;
            c7_tn = c7_sce;
            c7_td = c7_scc;
        end else if (r6_sgt) begin
            c7_sn = r6_den;
            c7_sd = r6_den;
            c7_tn = c7_sceb;
            c7_td = c7_scc;
        end else begin
            c7_sn = r6_sn;
            c7_sd = r6_den;
            c7_tn = r6_tn;
            c7_td = r6_den;
        end
    end

    always_comb begin
        c8_t = r7_tn[NW-1] ? -TW'(d7_d) : TW'(d7_b) - TW'(d7_d);
    end

    always_comb begin
        c9_sn = r8_sn;
        c9_sd = r8_sd;
        c9_tn = r8_tn;
        if (r8_tneg || r8_tgt) begin
            c9_tn = r8_tneg ? '0 : r8_td;
            if (r8_tlo) begin
                c9_sn = '0;
            end else if (r8_tha) begin
                c9_sn = r8_sd;
            end else begin
                c9_sn = NW'(r8_t) <<< (2 * F);
                c9_sd = NW'(d8_a) <<< (2 * F);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int j = 0; j < NUM_AXES; j++) begin
                r1_u[j]  <= c_u[j];
                r1_v[j]  <= c_v[j];
                r1_w[j]  <= c_w[j];
                r2_uu[j] <= r1_u[j] * r1_u[j];
                r2_uv[j] <= r1_u[j] * r1_v[j];
                r2_vv[j] <= r1_v[j] * r1_v[j];
                r2_uw[j] <= r1_u[j] * r1_w[j];
                r2_vw[j] <= r1_v[j] * r1_w[j];
            end
            r_geo[1] <= c_geo;
            for (int s = 2; s <= 10; s++) begin
                r_geo[s] <= r_geo[s-1];
            end
            r_dot[3] <= {c3_e, c3_d, c3_c, c3_b, c3_a};
            for (int s = 4; s <= 8; s++) begin
                r_dot[s] <= r_dot[s-1];
            end
            r4_ac   <= d3_a * d3_c;
            r4_bb   <= d3_b * d3_b;
            r4_be   <= d3_b * d3_e;
            r4_cd   <= d3_c * d3_d;
            r4_ae   <= d3_a * d3_e;
            r4_bd   <= d3_b * d3_d;
            r5_den  <= NW'(r4_ac) - NW'(r4_bb);
            r5_sn   <= NW'(r4_be) - NW'(r4_cd);
            r5_tn   <= NW'(r4_ae) - NW'(r4_bd);
            r6_den  <= r5_den;
            r6_sn   <= r5_sn;
            r6_tn   <= r5_tn;
            r6_par  <= f_below(r5_den, i_limit);
            r6_sneg <= r5_sn[NW-1];
            r6_sgt  <= r5_den < r5_sn;
            r7_sn   <= c7_sn;
            r7_sd   <= c7_sd;
            r7_tn   <= c7_tn;
            r7_td   <= c7_td;
            r7_par  <= r6_par;
            r8_sn   <= r7_sn;
            r8_sd   <= r7_sd;
            r8_tn   <= r7_tn;
            r8_td   <= r7_td;
            r8_par  <= r7_par;
            r8_tneg <= r7_tn[NW-1];
            r8_tgt  <= r7_td < r7_tn;
            r8_t    <= c8_t;
            r8_tlo  <= c8_t[TW-1];
            r8_tha  <= c8_t > TW'(d7_a);
            r9_sn   <= c9_sn;
            r9_sd   <= c9_sd;
            r9_tn   <= c9_tn;
            r9_td   <= r8_td;
            r9_par  <= r8_par;
            r10_sn  <= f_below(r9_sn, i_limit) ? '0 : r9_sn;
            r10_tn  <= f_below(r9_tn, i_limit) ? '0 : r9_tn;
            r10_sd  <= r9_sd;
            r10_td  <= r9_td;
            r10_par <= r9_par;
        end
    end

    assign o_valid = r_vld[9];
    assign o_item  = {r10_par, r10_td, r10_tn, r10_sd, r10_sn, r_geo[10]};

endmodule

// ===== src/spcp_fifo.sv =====
// ----------------------------------------------------------------------------
// spcp_fifo
// Small register queue between the front and back pipes.
// ----------------------------------------------------------------------------
module spcp_fifo
    import spcp_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output t_q_stat          o_stat
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wp;
    logic [AW-1:0]    r_rp;
    logic [CW-1:0]    r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_data          = r_mem[r_rp];
    assign o_stat.full     = (r_cnt == CW'(DEPTH));
    assign o_stat.nonempty = (r_cnt != '0);

endmodule

// ===== src/spcp_lane.sv =====
// ----------------------------------------------------------------------------
// spcp_lane
// One output coordinate: p0 + round(n * dir / den), split multiply then a
// one bit per stage restoring divide.
// ----------------------------------------------------------------------------
module spcp_lane
    import spcp_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int NUM_BITS   = 73
) (
    input  logic                    i_clk,
    input  t_lane_ctl               i_ctl,
    input  logic [COORD_BITS-1:0]   i_p0,
    input  logic signed [COORD_BITS:0] i_dir,
    input  logic signed [NUM_BITS-1:0] i_num,
    input  logic signed [NUM_BITS-1:0] i_den,
    output logic [COORD_BITS-1:0]   o_res
);

    localparam int CB  = COORD_BITS;
    localparam int DB  = CB + 1;
    localparam int NW  = NUM_BITS;
    localparam int NM  = NW - 1;
    localparam int NCH = (NM + CHUNK_BITS - 1) / CHUNK_BITS;
    localparam int PPW = CHUNK_BITS + CB;
    localparam int MW  = NM + CB;
    localparam int XW  = MW + 2;
    localparam int YW  = NM + 1;

    logic                   c_use;
    logic [DB-1:0]          c_adir;
    logic [NCH*CHUNK_BITS-1:0] c_nx;
    logic [MW-1:0]          c_mag;

    logic [PPW-1:0]         r_pp [NCH];
    logic [NM-1:0]          r1_den;
    logic [CB-1:0]          r1_p0;
    logic                   r1_neg;
    logic                   r1_use;

    logic [XW-1:0]          r_rem [CB];
    logic [YW-1:0]          r_y   [CB];
    logic [CB-1:0]          r_q   [CB+1];
    logic [CB-1:0]          r_p0  [CB+1];
    logic                   r_neg [CB+1];
    logic                   r_use [CB+1];
    logic [CB-1:0]          r_res;

    always_comb begin
        c_use  = i_ctl.vld && !i_num[NW-1] && (i_num != '0) && !i_den[NW-1] && (i_den != '0);
        c_adir = i_dir[DB-1] ? DB'(-i_dir) : DB'(i_dir);
        c_nx   = (NCH*CHUNK_BITS)'(i_num[NM-1:0]);
        c_mag  = '0;
        for (int c = 0; c < NCH; c++) begin
            c_mag = c_mag + (MW'(r_pp[c]) << (CHUNK_BITS * c));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int c = 0; c < NCH; c++) begin
                r_pp[c] <= PPW'(c_nx[c*CHUNK_BITS +: CHUNK_BITS]) * PPW'(c_adir[CB-1:0]);
            end
            r1_den <= i_den[NM-1:0];
            r1_p0  <= i_p0;
            r1_neg <= i_dir[DB-1];
            r1_use <= c_use;

            r_rem[0] <= {c_mag, 1'b0} + XW'(r1_den);
            r_y[0]   <= {r1_den, 1'b0};
            r_q[0]   <= '0;
            r_p0[0]  <= r1_p0;
            r_neg[0] <= r1_neg;
            r_use[0] <= r1_use;

            for (int s = 0; s < CB; s++) begin
                if (r_rem[s] >= (XW'(r_y[s]) << (CB - 1 - s))) begin
                    if (s < CB - 1) begin
                        r_rem[s+1] <= r_rem[s] - (XW'(r_y[s]) << (CB - 1 - s));
                    end
                    r_q[s+1] <= {r_q[s][CB-2:0], 1'b1};
                end else begin
                    if (s < CB - 1) begin
                        r_rem[s+1] <= r_rem[s];
                    end
                    r_q[s+1] <= {r_q[s][CB-2:0], 1'b0};
                end
                if (s < CB - 1) begin
                    r_y[s+1] <= r_y[s];
                end
                r_p0[s+1]  <= r_p0[s];
                r_neg[s+1] <= r_neg[s];
                r_use[s+1] <= r_use[s];
            end

            if (!r_use[CB]) begin
                r_res <= r_p0[CB];
            end else if (r_neg[CB]) begin
                r_res <= r_p0[CB] - r_q[CB];
            end else begin
                r_res <= r_p0[CB] + r_q[CB];
            end
        end
    end

    assign o_res = r_res;

endmodule

// ===== src/spcp_back.sv =====
// ----------------------------------------------------------------------------
// spcp_back
// Back pipe: six coordinate lanes fed from the queue head, valid tracking
// and the output register.
// ----------------------------------------------------------------------------
module spcp_back
    import spcp_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int NUM_BITS   = 73,
    parameter int ITEM_BITS  = 495
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [ITEM_BITS-1:0]         i_item,
    input  t_q_stat                      i_stat,
    output logic                         o_pop,
    input  logic                         i_ready,
    output logic                         o_valid,
    output logic [NUM_OUTS*COORD_BITS-1:0] o_data,
    output logic                         o_par
);

    localparam int CB  = COORD_BITS;
    localparam int DB  = CB + 1;
    localparam int NW  = NUM_BITS;
    localparam int OP  = 0;
    localparam int OQ  = 3 * CB;
    localparam int OU  = 6 * CB;
    localparam int OV  = 6 * CB + 3 * DB;
    localparam int GW  = 6 * CB + 6 * DB;
    localparam int OSN = GW;
    localparam int OSD = GW + NW;
    localparam int OTN = GW + 2 * NW;
    localparam int OTD = GW + 3 * NW;
    localparam int LAT = CB + 3;

    logic [LAT-1:0] r_vld;
    logic [LAT-1:0] r_par;
    logic           c_en;
    t_lane_ctl      c_ctl;

    assign c_en      = !r_vld[LAT-1] || i_ready;
    assign o_pop     = c_en && i_stat.nonempty;
    assign c_ctl.en  = c_en;
    assign c_ctl.vld = i_stat.nonempty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (c_en) begin
            r_vld <= {r_vld[LAT-2:0], i_stat.nonempty};
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_en) begin
            r_par <= {r_par[LAT-2:0], i_item[ITEM_BITS-1]};
        end
    end

    for (genvar k = 0; k < NUM_OUTS; k++) begin : g_lane
        localparam int AX  = k % NUM_AXES;
        localparam int PO  = ((k < NUM_AXES) ? OP : OQ) + AX * CB;
        localparam int DO  = ((k < NUM_AXES) ? OU : OV) + AX * DB;
        localparam int NO  = (k < NUM_AXES) ? OSN : OTN;
        localparam int DNO = (k < NUM_AXES) ? OSD : OTD;

        spcp_lane #(
            .COORD_BITS (CB),
            .NUM_BITS   (NW)
        ) u_lane (
            .i_clk  (i_clk),
            .i_ctl  (c_ctl),
            .i_p0   (i_item[PO +: CB]),
            .i_dir  ($signed(i_item[DO +: DB])),
            .i_num  ($signed(i_item[NO +: NW])),
            .i_den  ($signed(i_item[DNO +: NW])),
            .o_res  (o_data[k*CB +: CB])
        );
    end

    assign o_valid = r_vld[LAT-1];
    assign o_par   = r_par[LAT-1];

endmodule

// ===== src/segment_pair_closest_points.sv =====
// ----------------------------------------------------------------------------
// segment_pair_closest_points
// Closest points between two 3D segments in signed fixed point.
// ----------------------------------------------------------------------------
// Takes one segment pair per clock while s_axis_tready is high and returns
// the closest point on each segment plus a near-parallel flag, one result
// per input beat. Ten front stages compute the dot products, determinant
// and parameter clamping, the queue follows, then the back pipe, whose
// per-coordinate restoring divider resolves one quotient bit per stage. The
// four-entry queue between the pipes keeps the input accepting while a
// result waits on the output; s_axis_tready falls only once that queue has
// filled. small_limit is written through i_cfg_we/i_cfg_wdata; the user must
// write it only while the block is idle, which the block does not enforce.
module segment_pair_closest_points
    import spcp_pkg::*;
#(
    parameter int COORD_BITS = 16,
    parameter int FRAC_BITS  = 8,
    parameter int FIFO_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // seg1_p0_x, seg1_p0_y, seg1_p0_z, seg1_p1_x, seg1_p1_y, seg1_p1_z,
    // seg2_p0_x, seg2_p0_y, seg2_p0_z, seg2_p1_x, seg2_p1_y, seg2_p1_z
    input  logic [((NUM_COORDS*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // closest1_x, closest1_y, closest1_z, closest2_x, closest2_y, closest2_z
    output logic [((NUM_OUTS*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    // near_parallel
    output logic [0:0]  m_axis_tuser
);

    localparam int CB  = COORD_BITS;
    localparam int F   = FRAC_BITS;
    localparam int DB  = CB + 1;
    localparam int SW  = 2 * DB + 2;
    localparam int NA  = 2 * SW + 1;
    localparam int NB  = SW + 2 * F + 2;
    localparam int NC  = 4 * F + 2;
    localparam int NT  = (NA > NB) ? NA : NB;
    localparam int NW  = (NT > NC) ? NT : NC;
    localparam int IW  = 6 * CB + 6 * DB + 4 * NW + 1;
    localparam int ODW = ((NUM_OUTS * CB + 7) / 8) * 8;

    logic [31:0]              r_small_limit;
    logic                     c_f_en;
    logic                     c_f_valid;
    logic [IW-1:0]            c_f_item;
    logic [IW-1:0]            c_q_item;
    t_q_stat                  c_q_stat;
    logic                     c_pop;
    logic [NUM_OUTS*CB-1:0]   c_out;
    logic                     c_par;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_small_limit <= LIMIT_RESET;
        end else if (i_cfg_we) begin
            r_small_limit <= i_cfg_wdata;
        end
    end

    assign c_f_en        = !c_q_stat.full;
    assign s_axis_tready = c_f_en;

    spcp_front #(
        .COORD_BITS (CB),
        .FRAC_BITS  (F)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (c_f_en),
        .i_valid (s_axis_tvalid),
        .i_data  (s_axis_tdata[NUM_COORDS*CB-1:0]),
        .i_limit (r_small_limit),
        .o_valid (c_f_valid),
        .o_item  (c_f_item)
    );

    spcp_fifo #(
        .WIDTH (IW),
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (c_f_valid && c_f_en),
        .i_data  (c_f_item),
        .i_pop   (c_pop),
        .o_data  (c_q_item),
        .o_stat  (c_q_stat)
    );

    spcp_back #(
        .COORD_BITS (CB),
        .NUM_BITS   (NW),
        .ITEM_BITS  (IW)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (c_q_item),
        .i_stat  (c_q_stat),
        .o_pop   (c_pop),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_data  (c_out),
        .o_par   (c_par)
    );

    assign m_axis_tdata = ODW'(c_out);
    assign m_axis_tuser = c_par;

endmodule

// ===== src/spcp_chk.sv =====
// ----------------------------------------------------------------------------
// spcp_chk
// Port level checks for the closest point block, bound to the top level.
// ----------------------------------------------------------------------------
module spcp_chk #(
    parameter int COORD_BITS = 16
) (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [((6*COORD_BITS+7)/8)*8-1:0] m_axis_tdata,
    input logic [0:0]  m_axis_tuser
);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat valid right after reset");

    a_ready_only_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without an output stall");

    a_valid_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped while stalled");

    a_data_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output beat changed while stalled");

endmodule

bind segment_pair_closest_points spcp_chk #(.COORD_BITS(COORD_BITS)) u_spcp_chk (.*);
